@@ rtl/core/bsqrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bisection square root block.
// No dependencies; every other file of the block imports this package.

package bsqrt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int TOL_BITS  = 32;
    localparam int CNT_W     = 6;

    // Interval ends must hold 1.0 even when it does not fit in the word
    localparam int IV_W = (WORD_BITS > FRAC_BITS) ? WORD_BITS : FRAC_BITS + 1;
    localparam int SQ_W = 2 * IV_W;

    // Align the Q0.32 tolerance with the 2*FRAC_BITS fraction of the square
    localparam int TOL_SHL = (2 * FRAC_BITS >= TOL_BITS) ? 2 * FRAC_BITS - TOL_BITS : 0;
    localparam int TOL_SHR = (2 * FRAC_BITS >= TOL_BITS) ? 0 : TOL_BITS - 2 * FRAC_BITS;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(32'd4294967);
    localparam logic [IV_W-1:0]     ONE_FX    = IV_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]    CNT_MAX   = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE_END,
        ST_CHECK_END,
        ST_SQUARE,
        ST_EVAL,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic start_mid;
        logic step;
        logic capture;
        logic met;
    } dp_cmd_t;

    typedef struct packed {
        logic exact;
        logic in_tol;
        logic narrow;
    } dp_status_t;

endpackage

@@ rtl/core/bsqrt_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel carrying the tolerance register value.
// Depends on bsqrt_pkg for the register width.

interface bsqrt_cfg_if import bsqrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TOL_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bsqrt_operand_if.sv @@
`timescale 1ns / 1ps
// Input channel carrying one radicand per beat.
// Depends on bsqrt_pkg for the word width.

interface bsqrt_operand_if import bsqrt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink   (input valid, input radicand, output ready);
endinterface

@@ rtl/core/bsqrt_result_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying root, halving count and tolerance flag per beat.
// Depends on bsqrt_pkg for the field widths.

interface bsqrt_result_if import bsqrt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] root;
    logic [CNT_W-1:0]     halvings;
    logic                 tolerance_met;

    modport source (output valid, output root, output halvings, output tolerance_met,
                    input ready);
    modport sink   (input valid, input root, input halvings, input tolerance_met,
                    output ready);
endinterface

@@ rtl/core/bsqrt_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: interval bounds, squaring multiplier, error test and result register.
// Depends on bsqrt_pkg; driven by bsqrt_controller through dp_cmd_t.

module bsqrt_datapath import bsqrt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tol_wr,
    input  logic [TOL_BITS-1:0]  tol_data,
    input  logic [WORD_BITS-1:0] radicand,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic [WORD_BITS-1:0] root,
    output logic [CNT_W-1:0]     halvings,
    output logic                 tolerance_met
);

    logic [TOL_BITS-1:0]  tol_reg;
    logic [SQ_W-1:0]      target_reg;
    logic [IV_W-1:0]      lo_reg, lo_next;
    logic [IV_W-1:0]      hi_reg, hi_next;
    logic [IV_W-1:0]      x_reg, x_next;
    logic [SQ_W-1:0]      sq_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] root_reg;
    logic [CNT_W-1:0]     halvings_reg;
    logic                 met_reg;

    logic [IV_W-1:0]      v_ext;
    logic [IV_W-1:0]      hi_init;
    logic [SQ_W-1:0]      diff;
    logic [SQ_W-1:0]      tol_scaled;
    logic                 below;
    logic [IV_W:0]        sum_up, sum_down, sum_full;
    logic [IV_W-1:0]      width;

    assign v_ext   = IV_W'(radicand);
    assign hi_init = (v_ext > ONE_FX) ? v_ext : ONE_FX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (tol_wr)
        begin
            tol_reg <= tol_data;
        end
    end

    // Error test against the registered square
    assign below      = sq_reg < target_reg;
    assign diff       = below ? (target_reg - sq_reg) : (sq_reg - target_reg);
    assign tol_scaled = (SQ_W'(tol_reg) << TOL_SHL) >> TOL_SHR;
    assign width      = hi_reg - lo_reg;

    assign status.exact  = (sq_reg == target_reg);
    assign status.in_tol = (diff <= tol_scaled);
    assign status.narrow = (width <= IV_W'(1));

    // Both possible next midpoints of a halving, picked once the comparison settles, and the first midpoint
    assign sum_up   = {1'b0, x_reg} + {1'b0, hi_reg};
    assign sum_down = {1'b0, lo_reg} + {1'b0, x_reg};
    assign sum_full = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        x_next   = x_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            lo_next  = '0;
            hi_next  = hi_init;
            // zero radicand: square the low end so the exact test hits at once
            x_next   = (radicand == '0) ? '0 : hi_init;
            cnt_next = '0;
        end
        else if (cmd.start_mid)
        begin
            x_next = sum_full[IV_W:1];
        end
        else if (cmd.step)
        begin
            if (below)
            begin
                lo_next = x_reg;
                x_next  = sum_up[IV_W:1];
            end
            else
            begin
                hi_next = x_reg;
                x_next  = sum_down[IV_W:1];
            end
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        x_reg   <= x_next;
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            target_reg <= SQ_W'(radicand) << FRAC_BITS;
        end
        if (cmd.square)
        begin
            sq_reg <= SQ_W'(x_reg) * SQ_W'(x_reg);
        end
        if (cmd.capture)
        begin
            root_reg     <= x_reg[WORD_BITS-1:0];
            halvings_reg <= cnt_reg;
            met_reg      <= cmd.met;
        end
    end

    assign root          = root_reg;
    assign halvings      = halvings_reg;
    assign tolerance_met = met_reg;

`ifndef NO_ASSERTIONS
    a_step_wide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !status.narrow && !status.in_tol)
        else $error("halving issued on a settled interval");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> lo_reg < hi_reg)
        else $error("interval bounds crossed after halving");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (x_reg >= lo_reg) && (x_reg < hi_reg))
        else $error("midpoint outside interval");
`endif

endmodule

@@ rtl/core/bsqrt_controller.sv @@
`timescale 1ns / 1ps
// Controller: sequences end test and halvings, owns the operand and result handshakes.
// Depends on bsqrt_pkg; commands bsqrt_datapath through dp_cmd_t.

module bsqrt_controller import bsqrt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       operand_valid,
    output logic       operand_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        met_reg, met_next;
    logic        result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            met_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            met_reg          <= met_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        met_next          = met_reg;
        result_valid_next = result_valid_reg && !result_ready;
        cmd               = '0;
        cmd.met           = met_reg;
        operand_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                operand_ready = 1'b1;
                if (operand_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE_END;
                end
            end
            ST_SQUARE_END:
            begin
                cmd.square = 1'b1;
                state_next = ST_CHECK_END;
            end
            ST_CHECK_END:
            begin
                if (status.exact)
                begin
                    met_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start_mid = 1'b1;
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.in_tol)
                begin
                    met_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (status.narrow)
                begin
                    met_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH:
            begin
                // hold until the previous result beat has left
                if (!result_valid_reg || result_ready)
                begin
                    cmd.capture       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;

`ifndef NO_ASSERTIONS
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !result_valid_reg || result_ready)
        else $error("result register overwritten while occupied");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_SQUARE_END && !operand_ready)
        else $error("operand accepted while busy");
`endif

endmodule

@@ rtl/core/bisection_square_root.sv @@
`timescale 1ns / 1ps
// Top level of the bisection square root: controller, datapath, channel wiring.
// Depends on bsqrt_pkg, the three channel interfaces, bsqrt_controller, bsqrt_datapath.

// One radicand is worked at a time. After the operand beat the block squares the
// upper interval end (or zero) to test for an exact root; an exact hit goes straight
// to the result. Otherwise each halving passes through ST_SQUARE, in which the single
// registered multiplier squares the midpoint, and then ST_EVAL, for the error test and
// bound update. The reported halving count is at most 32 at the default sizes. A
// finished result is held back while a previous result still waits on the result
// port. The operand port opens again in the cycle the result appears. The tolerance
// may be written at any idle time and is always ready; it resets to about 0.001.

module bisection_square_root import bsqrt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    bsqrt_cfg_if.sink    cfg,
    bsqrt_operand_if.sink operand,
    bsqrt_result_if.source result
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       operand_ready;
    logic       result_valid;

    assign cfg.ready     = 1'b1;
    assign operand.ready = operand_ready;
    assign result.valid  = result_valid;

    bsqrt_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand.valid),
        .operand_ready (operand_ready),
        .result_valid  (result_valid),
        .result_ready  (result.ready),
        .status        (status),
        .cmd           (cmd)
    );

    bsqrt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .tol_wr        (cfg.valid),
        .tol_data      (cfg.data),
        .radicand      (operand.radicand),
        .cmd           (cmd),
        .status        (status),
        .root          (result.root),
        .halvings      (result.halvings),
        .tolerance_met (result.tolerance_met)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for bisection_square_root: directed and random radicands
// under several tolerance settings, checked against a bisection predictor.
// Depends on bsqrt_pkg, the three bsqrt channel interfaces and the block RTL.

module tb_top;
    import bsqrt_pkg::*;

    // The stall limit covers the longest item plus result stalls and sender gaps
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned PHASE_ITEMS  = 150;
    localparam int unsigned PHASE_COUNT  = 11;

    typedef struct packed {
        logic [WORD_BITS-1:0] radicand;
        logic [WORD_BITS-1:0] root;
        logic [CNT_W-1:0]     halvings;
        logic                 tolerance_met;
    } root_result_t;

    logic clk;
    logic rst_n;

    bsqrt_cfg_if     cfg_bus ();
    bsqrt_operand_if operand_bus ();
    bsqrt_result_if  result_bus ();

    bisection_square_root dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .operand (operand_bus),
        .result  (result_bus)
    );

    root_result_t         expected_roots[$];
    root_result_t         oldest_root;
    logic [TOL_BITS-1:0]  tolerance_copy;
    bit                   quiet;
    int unsigned          error_count;
    int unsigned          stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bisection predictor, carried out in 64-bit arithmetic
    function automatic root_result_t bisect_root(input logic [WORD_BITS-1:0] value,
                                                 input logic [TOL_BITS-1:0]  tol);
        logic [63:0]  v;
        logic [63:0]  target;
        logic [63:0]  one;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  sq;
        logic [63:0]  err;
        logic [63:0]  tol_scaled;
        int unsigned  count;
        bit           done;
        root_result_t res;
        v      = 64'(value);
        target = v << FRAC_BITS;
        one    = 64'd1 << FRAC_BITS;
        lo     = 64'd0;
        hi     = (v > one) ? v : one;
        count  = 0;
        done   = 1'b0;
        // Line up the Q0.32 tolerance with the fraction of the square
        if (2 * FRAC_BITS >= TOL_BITS)
            tol_scaled = 64'(tol) << (2 * FRAC_BITS - TOL_BITS);
        else
            tol_scaled = 64'(tol) >> (TOL_BITS - 2 * FRAC_BITS);
        res.radicand      = value;
        res.halvings      = '0;
        res.tolerance_met = 1'b1;
        if (v == 64'd0)
        begin
            res.root = '0;
            return res;
        end
        if (hi * hi == target)
        begin
            res.root = hi[WORD_BITS-1:0];
            return res;
        end
        mid = (lo + hi) >> 1;
        while (!done)
        begin
            sq  = mid * mid;
            err = (sq > target) ? sq - target : target - sq;
            if (err <= tol_scaled)
                done = 1'b1;
            else if (hi - lo <= 64'd1)
            begin
                res.tolerance_met = 1'b0;
                done = 1'b1;
            end
            else
            begin
                if (sq < target)
                    lo = mid;
                else
                    hi = mid;
                mid = (lo + hi) >> 1;
                if (count < 63)
                    count++;
            end
        end
        res.root     = mid[WORD_BITS-1:0];
        res.halvings = CNT_W'(count);
        return res;
    endfunction

    task automatic send_radicand(input logic [WORD_BITS-1:0] value);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 110) : $urandom_range(1, 8);
            operand_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operand_bus.valid    <= 1'b1;
        operand_bus.radicand <= value;
        @(posedge clk);
        while (!operand_bus.ready)
            @(posedge clk);
        expected_roots.push_back(bisect_root(value, tolerance_copy));
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        // Drop the operand channel and let the block drain before the write
        operand_bus.valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        tolerance_copy = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_reset_tolerance();
        send_radicand(32'h0000_0000);
        send_radicand(32'h0001_0000);
        send_radicand(32'h0000_4000);
        send_radicand(32'h0002_0000);
        send_radicand(32'h0000_0001);
        send_radicand(32'hFFFF_FFFF);
    endtask

    task automatic test_zero_tolerance();
        write_tolerance('0);
        send_radicand(32'h0009_0000);
        send_radicand(32'h0002_0000);
        send_radicand(32'h0000_0001);
        send_radicand(32'hFFFF_FFFF);
        send_radicand(32'h0000_8000);
        send_radicand(32'h0001_0000);
        send_radicand(32'h0001_0001);
        send_radicand(32'h8000_0000);
    endtask

    task automatic test_full_tolerance();
        write_tolerance('1);
        send_radicand(32'hFFFF_FFFF);
        send_radicand(32'h7FFF_FFFF);
        send_radicand(32'h1234_5678);
        send_radicand(32'h0000_0003);
        send_radicand(32'h0000_0000);
        send_radicand(32'h0000_FFFF);
    endtask

    task automatic test_random_sweep();
        logic [TOL_BITS-1:0]  tol;
        logic [WORD_BITS-1:0] value;
        int unsigned          pick;
        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 5)
                0: tol = TOL_RESET;
                1: tol = $urandom >> $urandom_range(0, 31);
                2: tol = '0;
                3: tol = $urandom;
                default: tol = (phase == PHASE_COUNT - 1) ? '1 : $urandom >> 16;
            endcase
            write_tolerance(tol);
            // Keep one phase free of idling on both sides
            quiet = (phase == 4);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    value = $urandom;
                else if (pick < 65)
                    value = $urandom_range(0, 32'h0001_FFFF);
                else if (pick < 82)
                    value = WORD_BITS'($urandom_range(0, 65535) ** 2);
                else
                    value = $urandom >> $urandom_range(0, 31);
                send_radicand(value);
            end
            quiet = 1'b0;
        end
    endtask

    // Result sink: stall at random unless in the quiet stretch
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_bus.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("%0t: result beat with nothing pending, root %h", $time,
                         result_bus.root);
                error_count++;
            end
            else
            begin
                oldest_root = expected_roots.pop_front();
                if (result_bus.root !== oldest_root.root)
                begin
                    $display("%0t: radicand %h root expected %h actual %h", $time,
                             oldest_root.radicand, oldest_root.root, result_bus.root);
                    error_count++;
                end
                if (result_bus.halvings !== oldest_root.halvings)
                begin
                    $display("%0t: radicand %h halvings expected %0d actual %0d", $time,
                             oldest_root.radicand, oldest_root.halvings,
                             result_bus.halvings);
                    error_count++;
                end
                if (result_bus.tolerance_met !== oldest_root.tolerance_met)
                begin
                    $display("%0t: radicand %h tolerance_met expected %b actual %b", $time,
                             oldest_root.radicand, oldest_root.tolerance_met,
                             result_bus.tolerance_met);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((operand_bus.valid && operand_bus.ready) ||
                (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        error_count          = 0;
        quiet                = 1'b0;
        tolerance_copy       = TOL_RESET;
        rst_n                <= 1'b0;
        operand_bus.valid    <= 1'b0;
        operand_bus.radicand <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.data         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_tolerance();
        test_zero_tolerance();
        test_full_tolerance();
        test_random_sweep();

        operand_bus.valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
